### rtl/core/prescaled_reloading_timer_core_assert.svh
// Assertion macros shared by the timer core modules
`ifndef PRESCALED_RELOADING_TIMER_CORE_ASSERT_SVH
`define PRESCALED_RELOADING_TIMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define PRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prt assertion failed");
// next-cycle implication, checked outside reset
`define PRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prt assertion failed");
`else
`define PRT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PRT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/prt_pkg.sv
// Types and constants for the prescaled reloading timer
package prt_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [1:0] REG_DIV    = 2'd0;
    localparam logic [1:0] REG_CNT    = 2'd1;
    localparam logic [1:0] REG_RELOAD = 2'd2;
    localparam logic [1:0] REG_CTL    = 2'd3;

    localparam int unsigned CTL_EN_BIT = 2;
    localparam logic [4:0]  CTL_READ_ONES = 5'b11111;

    localparam logic [1:0] RATE_256 = 2'd0;
    localparam logic [1:0] RATE_4   = 2'd1;
    localparam logic [1:0] RATE_16  = 2'd2;
    localparam logic [1:0] RATE_64  = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] reg_sel;
        logic [7:0] wdata;
    } t_in_item;

    typedef struct packed {
        logic [7:0] rdata;
        logic       timer_irq;
    } t_out_item;

    // prescaler period for a rate select code
    function automatic logic [8:0] rate_limit(input logic [1:0] rate);
        logic [8:0] lim;
        case (rate)
            RATE_256: lim = 9'd256;
            RATE_4:   lim = 9'd4;
            RATE_16:  lim = 9'd16;
            default:  lim = 9'd64;
        endcase
        return lim;
    endfunction

endpackage

### rtl/core/prt_timer_regs.sv
// Timer state registers and per-word update and read logic
`include "prescaled_reloading_timer_core_assert.svh"

module prt_timer_regs
    import prt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_exec,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    logic [13:0] r_div,      n_div;
    logic [7:0]  r_pre,      n_pre;
    logic [7:0]  r_cnt,      n_cnt;
    logic [7:0]  r_reload,   n_reload;
    logic [2:0]  r_ctl,      n_ctl;
    logic        r_irq_pend, n_irq_pend;

    logic [8:0] pre_inc;
    logic       running;
    logic       now_on;
    t_out_item  result;

    assign pre_inc = {1'b0, r_pre} + 9'd1;
    assign running = r_ctl[CTL_EN_BIT];
    assign now_on  = i_item.wdata[CTL_EN_BIT];

    always_comb begin
        n_div      = r_div;
        n_pre      = r_pre;
        n_cnt      = r_cnt;
        n_reload   = r_reload;
        n_ctl      = r_ctl;
        n_irq_pend = r_irq_pend;
        result     = '0;
        if (i_exec) begin
            unique case (i_item.op)
                OP_TICK: begin
                    result.timer_irq = r_irq_pend;
                    n_irq_pend       = 1'b0;
                    n_div            = r_div + 14'd1;
                    if (running) begin
                        if (pre_inc >= rate_limit(r_ctl[1:0])) begin
                            n_pre = '0;
                            if (r_cnt == 8'hff) begin
                                n_cnt      = r_reload;
                                n_irq_pend = 1'b1;
                            end else begin
                                n_cnt = r_cnt + 8'd1;
                            end
                        end else begin
                            n_pre = pre_inc[7:0];
                        end
                    end
                end
                OP_READ: begin
                    unique case (i_item.reg_sel)
                        REG_DIV:    result.rdata = r_div[13:6];
                        REG_CNT:    result.rdata = r_cnt;
                        REG_RELOAD: result.rdata = r_reload;
                        default:    result.rdata = {CTL_READ_ONES, r_ctl};
                    endcase
                end
                OP_WRITE: begin
                    unique case (i_item.reg_sel)
                        REG_DIV: n_div = '0;
                        REG_CNT: begin
                            n_cnt      = i_item.wdata;
                            n_pre      = '0;
                            n_irq_pend = 1'b0;
                        end
                        REG_RELOAD: begin
                            n_reload = i_item.wdata;
                            if (running) begin
                                n_pre = '0;
                            end
                        end
                        default: begin
                            // restart phase on start or on rate change while running
                            if (now_on && (!running || (i_item.wdata[1:0] != r_ctl[1:0]))) begin
                                n_pre = '0;
                            end
                            if (!now_on && running) begin
                                n_irq_pend = 1'b0;
                            end
                            n_ctl = i_item.wdata[2:0];
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div      <= '0;
            r_pre      <= '0;
            r_cnt      <= '0;
            r_reload   <= '0;
            r_ctl      <= '0;
            r_irq_pend <= 1'b0;
        end else begin
            r_div      <= n_div;
            r_pre      <= n_pre;
            r_cnt      <= n_cnt;
            r_reload   <= n_reload;
            r_ctl      <= n_ctl;
            r_irq_pend <= n_irq_pend;
        end
    end

    assign o_result = result;

    `PRT_ASSERT_NOW(a_irq_only_on_tick, i_clk, i_rst_n, i_exec && result.timer_irq, i_item.op == OP_TICK)
    `PRT_ASSERT_NOW(a_rdata_only_on_read, i_clk, i_rst_n, i_exec && (i_item.op != OP_READ), result.rdata == 8'd0)
    `PRT_ASSERT_NXT(a_cnt_write_clears, i_clk, i_rst_n, i_exec && (i_item.op == OP_WRITE) && (i_item.reg_sel == REG_CNT), (r_pre == 8'd0) && !r_irq_pend)
    `PRT_ASSERT_NXT(a_stopped_pre_holds, i_clk, i_rst_n, i_exec && !running && (i_item.op == OP_TICK), $stable(r_pre))

endmodule

### rtl/core/prescaled_reloading_timer_core.sv
// A word accepted into the input register has its result loaded into the result register as it moves on.
// Throughput: one word per cycle; the input register refills in the cycle its word moves on
// and holds while a result waits.
// The timer state updates as a word leaves the input register for the result register.
// Reset is synchronous and active low; it clears all timer state, stopping the timer,
// and empties both registers.
`include "prescaled_reloading_timer_core_assert.svh"

module prescaled_reloading_timer_core
    import prt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      advance;
    t_out_item result;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    prt_timer_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_exec   (advance),
        .i_item   (r_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `PRT_ASSERT_NXT(a_accept_fills_in, i_clk, i_rst_n, i_in_valid && o_in_ready, r_in_valid)
    `PRT_ASSERT_NXT(a_advance_fills_out, i_clk, i_rst_n, advance, r_out_valid)

endmodule

### bench/prescaled_reloading_timer_core_test.sv
// Self-checking bench for the prescaled reloading timer core: directed and random words
`timescale 1ns / 100ps

module prescaled_reloading_timer_core_test;
    import prt_pkg::*;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic [2:0] CTL_EN = 3'b100;
    localparam int unsigned RANDOM_WORDS = 850;
    localparam int unsigned CALM_TAIL = 150;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_word = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    // timer shadow state
    logic [13:0] div_cnt = '0;
    int unsigned presc = 0;
    logic [7:0]  tcnt = '0;
    logic [7:0]  reload = '0;
    logic [2:0]  ctl_bits = '0;
    logic        irq_pend = 1'b0;

    t_out_item   expected_words[$];
    bit          idle_on = 1'b1;
    int unsigned stall_left = 0;
    int unsigned error_count = 0;
    int unsigned sent_words = 0;
    int unsigned result_words = 0;
    int unsigned irq_seen = 0;
    int unsigned reads_seen = 0;

    prescaled_reloading_timer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned ticks_per_step(input logic [1:0] rate);
        int unsigned n;
        case (rate)
            RATE_256: n = 256;
            RATE_4:   n = 4;
            RATE_16:  n = 16;
            default:  n = 64;
        endcase
        return n;
    endfunction

    // advance the shadow timer by one word and return the result it should give
    function automatic t_out_item timer_step(input t_in_item w);
        t_out_item  r;
        logic [2:0] new_ctl;
        logic       was_on;
        r = '0;
        was_on = ctl_bits[CTL_EN_BIT];
        case (w.op)
            OP_TICK: begin
                r.timer_irq = irq_pend;
                irq_pend = 1'b0;
                div_cnt = div_cnt + 14'd1;
                if (was_on) begin
                    if (presc + 1 >= ticks_per_step(ctl_bits[1:0])) begin
                        presc = 0;
                        if (tcnt == 8'hff) begin
                            tcnt = reload;
                            irq_pend = 1'b1;
                        end else begin
                            tcnt = tcnt + 8'd1;
                        end
                    end else begin
                        presc = presc + 1;
                    end
                end
            end
            OP_READ: begin
                case (w.reg_sel)
                    REG_DIV:    r.rdata = div_cnt[13:6];
                    REG_CNT:    r.rdata = tcnt;
                    REG_RELOAD: r.rdata = reload;
                    default:    r.rdata = {CTL_READ_ONES, ctl_bits};
                endcase
            end
            OP_WRITE: begin
                case (w.reg_sel)
                    REG_DIV: div_cnt = '0;
                    REG_CNT: begin
                        tcnt = w.wdata;
                        presc = 0;
                        irq_pend = 1'b0;
                    end
                    REG_RELOAD: begin
                        reload = w.wdata;
                        if (was_on) presc = 0;
                    end
                    default: begin
                        new_ctl = w.wdata[2:0];
                        if (new_ctl[CTL_EN_BIT] && !was_on) presc = 0;
                        if (new_ctl[CTL_EN_BIT] && was_on && new_ctl[1:0] != ctl_bits[1:0])
                            presc = 0;
                        if (!new_ctl[CTL_EN_BIT] && was_on) irq_pend = 1'b0;
                        ctl_bits = new_ctl;
                    end
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_in_item word_of(input logic [1:0] op, input logic [1:0] sel,
                                         input logic [7:0] data);
        t_in_item w;
        w.op = op;
        w.reg_sel = sel;
        w.wdata = data;
        return w;
    endfunction

    // mostly ticks, with writes steered toward frequent overflows
    function automatic t_in_item pick_word();
        t_in_item    w;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        w.reg_sel = 2'($urandom_range(0, 3));
        w.wdata = 8'($urandom_range(0, 255));
        if (roll < 58) begin
            w.op = OP_TICK;
        end else if (roll < 78) begin
            w.op = OP_READ;
        end else if (roll < 95) begin
            w.op = OP_WRITE;
            if (w.reg_sel == REG_DIV && $urandom_range(0, 2) != 0)
                w.reg_sel = REG_CNT;
            if (w.reg_sel == REG_CNT && $urandom_range(0, 1) == 1)
                w.wdata[7:4] = 4'hf;
            if (w.reg_sel == REG_CTL) begin
                if ($urandom_range(0, 3) != 0) w.wdata[CTL_EN_BIT] = 1'b1;
                if ($urandom_range(0, 1) == 1) w.wdata[1:0] = RATE_4;
            end
        end else begin
            w.op = OP_SPARE;
        end
        return w;
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input t_in_item w);
        int unsigned gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_words.push_back(timer_step(w));
        sent_words++;
        @(negedge i_clk);
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_word(word_of(OP_TICK, REG_DIV, 8'h00));
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (expected_words.size() != 0);
    endtask

    task automatic test_reset_values();
        send_word(word_of(OP_READ, REG_DIV, 8'hff));
        send_word(word_of(OP_READ, REG_CNT, 8'h00));
        send_word(word_of(OP_READ, REG_RELOAD, 8'h55));
        send_word(word_of(OP_READ, REG_CTL, 8'haa));
        send_word(word_of(OP_SPARE, REG_CTL, 8'hff));
    endtask

    task automatic test_register_access();
        send_word(word_of(OP_WRITE, REG_CNT, 8'hff));
        send_word(word_of(OP_READ, REG_CNT, 8'h00));
        send_word(word_of(OP_WRITE, REG_RELOAD, 8'hff));
        send_word(word_of(OP_READ, REG_RELOAD, 8'h00));
        send_word(word_of(OP_WRITE, REG_CTL, 8'hff));
        send_word(word_of(OP_READ, REG_CTL, 8'h00));
        send_word(word_of(OP_WRITE, REG_CTL, 8'h00));
        send_word(word_of(OP_WRITE, REG_DIV, 8'h5a));
        send_word(word_of(OP_READ, REG_DIV, 8'h00));
    endtask

    task automatic test_overflow_cases();
        send_word(word_of(OP_WRITE, REG_RELOAD, 8'hc3));
        send_word(word_of(OP_WRITE, REG_CNT, 8'hfe));
        send_word(word_of(OP_WRITE, REG_CTL, {5'b0, CTL_EN[2], RATE_4}));
        send_ticks(8);
        // interrupt must survive the bus read and show on the next tick
        send_word(word_of(OP_READ, REG_CNT, 8'h00));
        send_ticks(2);
        // counter write cancels the pending interrupt
        send_word(word_of(OP_WRITE, REG_CNT, 8'hff));
        send_ticks(4);
        send_word(word_of(OP_WRITE, REG_CNT, 8'h10));
        send_ticks(1);
        // stopping the timer cancels it too
        send_word(word_of(OP_WRITE, REG_CNT, 8'hff));
        send_ticks(4);
        send_word(word_of(OP_WRITE, REG_CTL, {5'b0, 1'b0, RATE_4}));
        send_ticks(1);
        hold_until_drained();
    endtask

    task automatic test_random_traffic();
        for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
            if (i % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if (i >= RANDOM_WORDS - CALM_TAIL) idle_on = 1'b0;
            if (i % 200 == 199) hold_until_drained();
            send_word(pick_word());
        end
    endtask

    // random backpressure on the result side; drop any stall once idling ends
    always @(negedge i_clk) begin
        if (!idle_on) begin
            stall_left = 0;
            out_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && out_ready) begin
            result_words++;
            if (o_out_item.timer_irq) irq_seen++;
            if (expected_words.size() == 0) begin
                error_count++;
                $error("result word with nothing expected: rdata %0h timer_irq %0b",
                       o_out_item.rdata, o_out_item.timer_irq);
            end else begin
                want = expected_words.pop_front();
                if (o_out_item.rdata !== want.rdata) begin
                    error_count++;
                    $error("rdata: expected %0h, got %0h", want.rdata, o_out_item.rdata);
                end
                if (o_out_item.timer_irq !== want.timer_irq) begin
                    error_count++;
                    $error("timer_irq: expected %0b, got %0b",
                           want.timer_irq, o_out_item.timer_irq);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", expected_words.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_values();
        test_register_access();
        test_overflow_cases();
        test_random_traffic();
        idle_on = 1'b0;
        hold_until_drained();
        repeat (6) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            error_count++;
            $error("%0d expected results never arrived", expected_words.size());
        end
        $display("Sent %0d words (ticks, reads, writes, unused op) and checked %0d results;",
                 sent_words, result_words);
        $display("%0d timer interrupts observed under random input gaps and output stalls.",
                 irq_seen);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
